// ===== rtl/mids_pkg.sv =====
// Package for the meal and insulin delivery scheduler.
// Word format, payload structs, sequencer states, divider handshake, saturating helpers.
// No dependencies.
package mids_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 16;
    localparam int DIV_BITS      = WORD_BITS + FRACTION_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_BITS);
    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_BITS - 1);
    localparam logic [WORD_BITS-1:0] INTAKE_LIMIT_RESET = WORD_BITS'(327680);
    localparam logic [WORD_BITS-1:0] SMALL_THRESH =
        WORD_BITS'(((64'd1 << FRACTION_BITS) + 64'd50000) / 64'd100000);

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        t_word insulin_request;
        t_word carb_request;
        t_word step_time;
        t_word stomach_first;
        t_word stomach_second;
    } t_in_item;

    typedef struct packed {
        t_word carb_rate;
        t_word insulin_rate;
        t_word insulin_pending;
        t_word carbs_pending;
        t_word meal_total;
        t_word stomach_snapshot;
        logic  eating;
    } t_out_item;

    typedef struct packed {
        logic  start;
        t_word num;
        t_word den;
    } t_div_req;

    typedef struct packed {
        logic  busy;
        logic  done;
        t_word quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_I,
        S_INS,
        S_WAIT_I,
        S_CARB,
        S_WAIT_C,
        S_UQ,
        S_WAIT_U,
        S_MUL_C,
        S_UPD
    } t_state;

    function automatic t_word sat_add(input t_word a, input t_word b);
        logic [WORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_BITS] ? '1 : s[WORD_BITS-1:0];
    endfunction

    function automatic t_word sat_sub(input t_word a, input t_word b);
        return (a > b) ? a - b : '0;
    endfunction

endpackage

// ===== rtl/mids_mul.sv =====
// Fixed-point multiplier with registered, saturated result.
// Depends on mids_pkg.
module mids_mul (
    input  logic           i_clk,
    input  mids_pkg::t_word i_a,
    input  mids_pkg::t_word i_b,
    output mids_pkg::t_word o_p
);
    logic [2*mids_pkg::WORD_BITS-1:0] prod;
    mids_pkg::t_word r_p;
    mids_pkg::t_word n_p;

    always_comb begin
        prod = {{mids_pkg::WORD_BITS{1'b0}}, i_a} * {{mids_pkg::WORD_BITS{1'b0}}, i_b};
        if (|prod[2*mids_pkg::WORD_BITS-1:mids_pkg::DIV_BITS]) begin
            n_p = '1;
        end else begin
            n_p = prod[mids_pkg::DIV_BITS-1:mids_pkg::FRACTION_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;
endmodule

// ===== rtl/mids_div.sv =====
// Iterative restoring fixed-point divider, one quotient bit per cycle.
// Depends on mids_pkg.
module mids_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mids_pkg::t_div_req i_req,
    output mids_pkg::t_div_rsp o_rsp
);
    logic [mids_pkg::DIV_BITS-1:0]     r_num, n_num;
    mids_pkg::t_word                   r_rem, n_rem;
    mids_pkg::t_word                   r_den;
    logic [mids_pkg::DIV_CNT_BITS-1:0] r_cnt;
    logic                              r_busy;
    logic                              r_done;
    logic [mids_pkg::WORD_BITS:0]      trial;
    logic                              ge;

    always_comb begin
        trial = {r_rem, r_num[mids_pkg::DIV_BITS-1]};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? mids_pkg::WORD_BITS'(trial - {1'b0, r_den})
                   : trial[mids_pkg::WORD_BITS-1:0];
        n_num = {r_num[mids_pkg::DIV_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mids_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end else if (i_req.start) begin
            r_num <= {i_req.num, {mids_pkg::FRACTION_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= i_req.den;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = (|r_num[mids_pkg::DIV_BITS-1:mids_pkg::WORD_BITS]) ? '1
                        : r_num[mids_pkg::WORD_BITS-1:0];
endmodule

// ===== rtl/meal_insulin_delivery_scheduler.sv =====
// Meal and insulin delivery scheduler top level: sequencer, state, output register.
// At most three divisions per tick on the shared divider: the insulin rate needs one only
// when the total insulin falls short of rate times tick length; a zero tick length needs none.
// One tick at a time: input stalls until the result is registered.
// Reset (synchronous, active low) clears all bookkeeping and loads the intake limit with 5.0.
// Depends on mids_pkg, mids_mul, mids_div.
module meal_insulin_delivery_scheduler (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mids_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mids_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  mids_pkg::t_word     i_cfg_wdata
);
    mids_pkg::t_state r_state, n_state;

    mids_pkg::t_word r_intake_limit;
    mids_pkg::t_word r_pend_ins, r_prev_rate, r_pend_carbs, r_meal, r_snap;
    logic            r_eating;
    mids_pkg::t_in_item r_in;
    mids_pkg::t_word r_irate, r_total, r_cq, r_crate;
    logic            r_out_valid;
    mids_pkg::t_out_item r_out;

    mids_pkg::t_word    mul_a, mul_p;
    mids_pkg::t_div_req div_req;
    mids_pkg::t_div_rsp div_rsp;

    logic            in_xfer, out_free;
    mids_pkg::t_word irate0, rem, crate_sel, left, meal_n;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != mids_pkg::S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign mul_a = (r_state == mids_pkg::S_MUL_I) ? r_irate : r_crate;

    mids_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (r_in.step_time),
        .o_p   (mul_p)
    );

    mids_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        if (r_pend_ins == '0) begin
            irate0 = i_in.insulin_request;
        end else begin
            irate0 = (i_in.insulin_request >= r_prev_rate) ? i_in.insulin_request : r_prev_rate;
        end
        rem = mids_pkg::sat_sub(r_total, mul_p);
        if (r_cq >= r_intake_limit
                || (div_rsp.quot >= r_intake_limit && r_pend_carbs == '0)) begin
            crate_sel = r_intake_limit;
        end else if (r_in.carb_request != '0 && r_pend_carbs == '0) begin
            crate_sel = div_rsp.quot;
        end else begin
            crate_sel = r_cq;
        end
        left = mids_pkg::sat_sub(mids_pkg::sat_add(r_in.carb_request, r_pend_carbs), mul_p);
        if (r_eating) begin
            meal_n = mids_pkg::sat_add(r_meal, mul_p);
        end else if (r_crate != '0) begin
            meal_n = mul_p;
        end else begin
            meal_n = r_meal;
        end
    end

    always_comb begin
        n_state       = r_state;
        div_req.start = 1'b0;
        div_req.num   = r_total;
        div_req.den   = r_in.step_time;
        case (r_state)
            mids_pkg::S_IDLE: begin
                if (in_xfer) n_state = mids_pkg::S_MUL_I;
            end
            mids_pkg::S_MUL_I: n_state = mids_pkg::S_INS;
            mids_pkg::S_INS: begin
                if (r_in.step_time != '0 && r_total < mul_p) begin
                    div_req.start = 1'b1;
                    n_state = mids_pkg::S_WAIT_I;
                end else begin
                    n_state = mids_pkg::S_CARB;
                end
            end
            mids_pkg::S_WAIT_I: begin
                if (div_rsp.done) n_state = mids_pkg::S_CARB;
            end
            mids_pkg::S_CARB: begin
                if (r_in.step_time == '0) begin
                    n_state = mids_pkg::S_MUL_C;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = r_pend_carbs;
                    n_state = mids_pkg::S_WAIT_C;
                end
            end
            mids_pkg::S_WAIT_C: begin
                if (div_rsp.done) n_state = mids_pkg::S_UQ;
            end
            mids_pkg::S_UQ: begin
                div_req.start = 1'b1;
                div_req.num   = r_in.carb_request;
                n_state = mids_pkg::S_WAIT_U;
            end
            mids_pkg::S_WAIT_U: begin
                if (div_rsp.done) n_state = mids_pkg::S_MUL_C;
            end
            mids_pkg::S_MUL_C: n_state = mids_pkg::S_UPD;
            mids_pkg::S_UPD: begin
                if (out_free) n_state = mids_pkg::S_IDLE;
            end
            default: n_state = mids_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mids_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intake_limit <= mids_pkg::INTAKE_LIMIT_RESET;
            r_pend_ins     <= '0;
            r_prev_rate    <= '0;
            r_pend_carbs   <= '0;
            r_meal         <= '0;
            r_snap         <= '0;
            r_eating       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) r_intake_limit <= i_cfg_wdata;
            if (r_state == mids_pkg::S_UPD && out_free) begin
                r_pend_ins   <= r_total;
                r_prev_rate  <= r_irate;
                r_pend_carbs <= left;
                r_meal       <= meal_n;
                if (r_crate != '0 && !r_eating) begin
                    r_eating <= 1'b1;
                    r_snap   <= mids_pkg::sat_add(r_in.stomach_first, r_in.stomach_second);
                end else if (r_crate == '0 && r_eating) begin
                    r_eating <= 1'b0;
                end
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            mids_pkg::S_IDLE: begin
                if (in_xfer) begin
                    r_in    <= i_in;
                    r_irate <= irate0;
                    r_total <= mids_pkg::sat_add(r_pend_ins, i_in.insulin_request);
                end
            end
            mids_pkg::S_INS: begin
                if (!(r_in.step_time != '0 && r_total < mul_p)) begin
                    r_total <= (rem < mids_pkg::SMALL_THRESH) ? '0 : rem;
                end
                r_crate <= '0;
            end
            mids_pkg::S_WAIT_I: begin
                if (div_rsp.done) begin
                    r_irate <= div_rsp.quot;
                    r_total <= '0;
                end
            end
            mids_pkg::S_WAIT_C: begin
                if (div_rsp.done) r_cq <= div_rsp.quot;
            end
            mids_pkg::S_WAIT_U: begin
                if (div_rsp.done) r_crate <= crate_sel;
            end
            mids_pkg::S_UPD: begin
                if (out_free) begin
                    r_out.carb_rate        <= r_crate;
                    r_out.insulin_rate     <= r_irate;
                    r_out.insulin_pending  <= r_total;
                    r_out.carbs_pending    <= left;
                    r_out.meal_total       <= meal_n;
                    r_out.stomach_snapshot <= (r_crate != '0 && !r_eating)
                        ? mids_pkg::sat_add(r_in.stomach_first, r_in.stomach_second) : r_snap;
                    r_out.eating           <= (r_crate != '0);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed under stall");

    a_eat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.eating == (o_out.carb_rate != '0)))
        else $error("eating flag disagrees with carb rate");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy && r_state != mids_pkg::S_IDLE)
        else $error("divider started while busy");
endmodule

// ===== tb/sv/mids_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the meal and insulin delivery scheduler: watches both channels and the
// intake limit write port, predicts each result from its own state copy and compares.
// Depends on mids_pkg.
module mids_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  mids_pkg::t_in_item  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  mids_pkg::t_out_item i_out,
    input  logic                i_cfg_we,
    input  mids_pkg::t_word     i_cfg_wdata,
    output int                  o_errors,
    output int                  o_waiting
);
    localparam int F = mids_pkg::FRACTION_BITS;
    localparam logic [63:0] WMAX = (64'd1 << mids_pkg::WORD_BITS) - 1;

    mids_pkg::t_word     ins_left, last_irate, carbs_left, eaten_sum, snap, intake_limit;
    logic                at_meal;
    mids_pkg::t_out_item sched_q[$];

    function automatic mids_pkg::t_word qmul(input mids_pkg::t_word a,
                                             input mids_pkg::t_word b);
        logic [63:0] p;
        p = (64'(a) * 64'(b)) >> F;
        return (p > WMAX) ? '1 : mids_pkg::t_word'(p);
    endfunction

    function automatic mids_pkg::t_word qdiv(input mids_pkg::t_word a,
                                             input mids_pkg::t_word b);
        logic [63:0] q;
        q = (64'(a) << F) / 64'(b);
        return (q > WMAX) ? '1 : mids_pkg::t_word'(q);
    endfunction

    function automatic mids_pkg::t_word qadd(input mids_pkg::t_word a,
                                             input mids_pkg::t_word b);
        logic [mids_pkg::WORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[mids_pkg::WORD_BITS] ? '1 : s[mids_pkg::WORD_BITS-1:0];
    endfunction

    function automatic mids_pkg::t_word qsub(input mids_pkg::t_word a,
                                             input mids_pkg::t_word b);
        return (a > b) ? a - b : '0;
    endfunction

    task automatic schedule_tick(input mids_pkg::t_in_item t);
        mids_pkg::t_word     irate, total, prod, crate, cq, uq, eaten;
        mids_pkg::t_out_item r;
        irate = (ins_left == 0 || t.insulin_request >= last_irate) ? t.insulin_request
                                                                      : last_irate;
        total = qadd(ins_left, t.insulin_request);
        prod  = qmul(irate, t.step_time);
        if (t.step_time != 0 && total < prod) begin
            irate = qdiv(total, t.step_time);
            total = 0;
        end else begin
            total = qsub(total, prod);
            if (total < mids_pkg::SMALL_THRESH) total = 0;
        end
        crate = 0;
        if (t.step_time != 0) begin
            cq = qdiv(carbs_left, t.step_time);
            uq = qdiv(t.carb_request, t.step_time);
            if (cq >= intake_limit || (uq >= intake_limit && carbs_left == 0))
                crate = intake_limit;
            else if (t.carb_request > 0 && uq < intake_limit && carbs_left == 0)
                crate = uq;
            else
                crate = cq;
        end
        eaten = qmul(crate, t.step_time);
        carbs_left = qsub(qadd(t.carb_request, carbs_left), eaten);
        if (at_meal) eaten_sum = qadd(eaten_sum, eaten);
        else if (crate > 0) eaten_sum = eaten;
        if (crate > 0 && !at_meal) begin
            at_meal = 1'b1;
            snap = qadd(t.stomach_first, t.stomach_second);
        end else if (crate == 0 && at_meal) begin
            at_meal = 1'b0;
        end
        ins_left   = total;
        last_irate = irate;
        r.carb_rate        = crate;
        r.insulin_rate     = irate;
        r.insulin_pending  = ins_left;
        r.carbs_pending    = carbs_left;
        r.meal_total       = eaten_sum;
        r.stomach_snapshot = snap;
        r.eating           = at_meal;
        sched_q.push_back(r);
    endtask

    task automatic cmp(input string nm, input mids_pkg::t_word e, input mids_pkg::t_word a);
        if (e !== a) begin
            $display("%0t: %s expected %h actual %h", $time, nm, e, a);
            o_errors++;
        end
    endtask

    initial o_errors = 0;
    assign o_waiting = sched_q.size();

    always @(posedge i_clk) begin
        mids_pkg::t_out_item e;
        if (!i_rst_n) begin
            ins_left = '0; last_irate = '0; carbs_left = '0;
            eaten_sum = '0; snap = '0; at_meal = 1'b0;
            intake_limit = mids_pkg::INTAKE_LIMIT_RESET;
        end else begin
            if (i_cfg_we) intake_limit = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) schedule_tick(i_in);
            if (i_out_valid && !i_out_stall) begin
                if (sched_q.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none actual %h", $time, i_out);
                    o_errors++;
                end else begin
                    e = sched_q.pop_front();
                    cmp("carb_rate", e.carb_rate, i_out.carb_rate);
                    cmp("insulin_rate", e.insulin_rate, i_out.insulin_rate);
                    cmp("insulin_pending", e.insulin_pending, i_out.insulin_pending);
                    cmp("carbs_pending", e.carbs_pending, i_out.carbs_pending);
                    cmp("meal_total", e.meal_total, i_out.meal_total);
                    cmp("stomach_snapshot", e.stomach_snapshot, i_out.stomach_snapshot);
                    cmp("eating", mids_pkg::t_word'(e.eating), mids_pkg::t_word'(i_out.eating));
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the scheduler testbench: clock, reset, tick stimulus, intake limit phases, verdict.
// Depends on mids_pkg, mids_checker and the scheduler RTL.
module tb_top;
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    mids_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    mids_pkg::t_out_item out_item;
    logic                cfg_we = 1'b0;
    mids_pkg::t_word     cfg_wdata = '0;
    logic                quiet = 1'b0;
    int                  errors, waiting;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    meal_insulin_delivery_scheduler i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_item),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata)
    );

    mids_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out(out_item),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_errors(errors), .o_waiting(waiting)
    );

    // receiver stall bursts
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 13);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic mids_pkg::t_word rnd_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return mids_pkg::t_word'($urandom_range(0, 3));
            3: return mids_pkg::t_word'($urandom_range(0, 32'h000A_0000));
            4: return mids_pkg::t_word'($urandom_range(0, 32'h0064_0000));
            default: return $urandom;
        endcase
    endfunction

    function automatic mids_pkg::t_in_item rnd_tick();
        mids_pkg::t_in_item t;
        t.insulin_request = ($urandom_range(0, 2) == 0) ? rnd_word()
                            : mids_pkg::t_word'($urandom_range(0, 32'h3_0000));
        t.carb_request    = ($urandom_range(0, 3) == 0) ? rnd_word() : '0;
        case ($urandom_range(0, 7))
            0: t.step_time = '0;
            1: t.step_time = rnd_word();
            default: t.step_time = mids_pkg::t_word'($urandom_range(32'h4000, 32'h5_0000));
        endcase
        t.stomach_first  = rnd_word();
        t.stomach_second = rnd_word();
        return t;
    endfunction

    task automatic send_tick(input mids_pkg::t_in_item t);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_item  <= t;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (waiting != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_intake_limit(input mids_pkg::t_word v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        mids_pkg::t_word rates[6];
        rates = '{32'h0005_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                  32'h0001_8000, 32'h0014_0000};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, zero tick, meal start and end, saturation
        send_tick('{32'h2_0000, 32'h14_0000, 32'h1_0000, 32'h10_0000, 32'h5_0000});
        send_tick('{32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0});
        send_tick('{32'h1_0000, 32'h0, 32'h0, 32'h1, 32'h2});
        send_tick('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_tick('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h8000_0000});
        send_tick('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        send_tick('{32'h1, 32'h1, 32'h1, 32'h0, 32'h0});
        send_tick('{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0});
        for (int i = 0; i < 12; i++) send_tick(rnd_tick());
        drain();
        for (int p = 0; p < 6; p++) begin
            set_intake_limit(rates[p]);
            if (p == 5) quiet = 1'b1;
            for (int i = 0; i < 230; i++) send_tick(rnd_tick());
            drain();
        end
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
